// ===== rtl/mips_instruction_executor_assert.svh =====
// Assertion macros; clk and rst_n must be in scope where they are used.
`ifndef MIPS_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define MIPS_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Same-cycle implication.
`define MIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("executor assertion failed");

// Next-cycle implication.
`define MIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("executor assertion failed");

`endif

// ===== rtl/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;

    localparam int LOAD_ADDR_W = 20;

    // item operations
    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SYSCALL = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_SLTI    = 6'h0a;
    localparam logic [5:0] OPC_SLTIU   = 6'h0b;
    localparam logic [5:0] OPC_ANDI    = 6'h0c;
    localparam logic [5:0] OPC_ORI     = 6'h0d;
    localparam logic [5:0] OPC_XORI    = 6'h0e;
    localparam logic [5:0] OPC_LUI     = 6'h0f;
    localparam logic [5:0] OPC_LB      = 6'h20;
    localparam logic [5:0] OPC_LH      = 6'h21;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_LBU     = 6'h24;
    localparam logic [5:0] OPC_LHU     = 6'h25;
    localparam logic [5:0] OPC_SB      = 6'h28;
    localparam logic [5:0] OPC_SH      = 6'h29;
    localparam logic [5:0] OPC_SW      = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    localparam logic [31:0] PC_SEG_MASK = 32'hf0000000;

    typedef enum logic [3:0] {
        CL_NOP,
        CL_PWR,
        CL_PRD,
        CL_ILLEGAL,
        CL_RTYPE,
        CL_JR,
        CL_SYSCALL,
        CL_MULT,
        CL_MULTU,
        CL_JUMP,
        CL_BRANCH,
        CL_IMM,
        CL_LOAD,
        CL_STORE
    } cls_t;

    typedef struct packed {
        cls_t                   cls;
        logic [31:0]            iw;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [31:0]            load_data;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_written;
        logic [31:0] store_address;
        logic [31:0] store_value;
        logic [31:0] read_data;
    } res_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EXEC,
        BS_MUL,
        BS_MEM
    } bstate_t;

endpackage

// ===== rtl/mie_ifs.sv =====
`timescale 1ns / 1ps
interface mie_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     operation;
    logic [31:0]                    instruction_word;
    logic [mie_pkg::LOAD_ADDR_W-1:0] load_address;
    logic [31:0]                    load_data;

    modport source (output valid, operation, instruction_word, load_address, load_data,
                    input ready);
    modport sink (input valid, operation, instruction_word, load_address, load_data,
                  output ready);
endinterface

interface mie_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [31:0] store_address;
    logic [31:0] store_value;
    logic [31:0] read_data;

    modport source (output valid, status, next_pc, reg_written, reg_index, reg_value,
                    mem_written, store_address, store_value, read_data, input ready);
    modport sink (input valid, status, next_pc, reg_written, reg_index, reg_value,
                  mem_written, store_address, store_value, read_data, output ready);
endinterface

interface mie_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_pc;

    modport source (output valid, start_pc, input ready);
    modport sink (input valid, start_pc, output ready);
endinterface

// ===== rtl/mie_ram.sv =====
`timescale 1ns / 1ps
module mie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mie_front.sv =====
`timescale 1ns / 1ps
module mie_front (
    input  logic           clk,
    input  logic           rst_n,
    mie_req_if.sink        req,
    output logic           q_valid,
    output mie_pkg::item_t q_item,
    input  logic           q_pop
);

    function automatic mie_pkg::cls_t classify(input logic [1:0] op, input logic [31:0] iw);
        logic [5:0] opc;
        logic [5:0] fn;
        mie_pkg::cls_t c;
        opc = iw[31:26];
        fn  = iw[5:0];
        c   = mie_pkg::CL_NOP;
        case (op)
            mie_pkg::OP_WRITE: c = mie_pkg::CL_PWR;
            mie_pkg::OP_READ:  c = mie_pkg::CL_PRD;
            mie_pkg::OP_EXEC:
            begin
                if (opc == mie_pkg::OPC_SPECIAL)
                begin
                    case (fn) inside
                        mie_pkg::FN_SLL, mie_pkg::FN_SRL, mie_pkg::FN_SRA, mie_pkg::FN_JALR,
                        mie_pkg::FN_MFHI, mie_pkg::FN_MFLO, mie_pkg::FN_ADDU, mie_pkg::FN_SUBU,
                        mie_pkg::FN_AND, mie_pkg::FN_OR, mie_pkg::FN_XOR, mie_pkg::FN_NOR,
                        mie_pkg::FN_SLT, mie_pkg::FN_SLTU: c = mie_pkg::CL_RTYPE;
                        mie_pkg::FN_JR:      c = mie_pkg::CL_JR;
                        mie_pkg::FN_SYSCALL: c = mie_pkg::CL_SYSCALL;
                        mie_pkg::FN_MULT:    c = mie_pkg::CL_MULT;
                        mie_pkg::FN_MULTU:   c = mie_pkg::CL_MULTU;
                        default:             c = mie_pkg::CL_ILLEGAL;
                    endcase
                end
                else
                begin
                    case (opc) inside
                        mie_pkg::OPC_J, mie_pkg::OPC_JAL:     c = mie_pkg::CL_JUMP;
                        mie_pkg::OPC_BEQ, mie_pkg::OPC_BNE:   c = mie_pkg::CL_BRANCH;
                        mie_pkg::OPC_ADDIU, mie_pkg::OPC_SLTI, mie_pkg::OPC_SLTIU,
                        mie_pkg::OPC_ANDI, mie_pkg::OPC_ORI, mie_pkg::OPC_XORI,
                        mie_pkg::OPC_LUI:                     c = mie_pkg::CL_IMM;
                        mie_pkg::OPC_LB, mie_pkg::OPC_LH, mie_pkg::OPC_LW,
                        mie_pkg::OPC_LBU, mie_pkg::OPC_LHU:   c = mie_pkg::CL_LOAD;
                        mie_pkg::OPC_SB, mie_pkg::OPC_SH,
                        mie_pkg::OPC_SW:                      c = mie_pkg::CL_STORE;
                        default:                              c = mie_pkg::CL_ILLEGAL;
                    endcase
                end
            end
            default: c = mie_pkg::CL_NOP;
        endcase
        return c;
    endfunction

    // two-entry queue to the executor
    mie_pkg::item_t fifo_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           push;
    mie_pkg::item_t new_item;

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.cls          = classify(req.operation, req.instruction_word);
        new_item.iw           = req.instruction_word;
        new_item.load_address = req.load_address;
        new_item.load_data    = req.load_data;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/mie_back.sv =====
`timescale 1ns / 1ps
module mie_back #(
    parameter int MEM_ADDR_BITS = 20
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  mie_pkg::item_t q_item,
    output logic           q_pop,
    mie_cfg_if.sink        cfg,
    mie_rsp_if.source      rsp
);

    localparam int WIDX_BITS = MEM_ADDR_BITS - 2;
    localparam int MEM_WORDS = 1 << WIDX_BITS;

    mie_pkg::bstate_t state_reg;
    mie_pkg::bstate_t state_next;
    mie_pkg::item_t   item_reg;
    logic             vld_a_reg;
    logic             vld_b_reg;
    logic [31:0]      rf_vld_reg;
    logic [31:0]      pc_reg;
    logic [31:0]      hi_reg;
    logic [31:0]      lo_reg;
    logic [63:0]      prod_reg;
    logic [63:0]      prod_next;
    mie_pkg::res_t    out_reg;
    logic             out_vld_reg;

    logic [31:0] rf_rdata_a;
    logic [31:0] rf_rdata_b;
    logic        rf_re;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] iw;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rdn;
    logic [4:0]  shamt;
    logic [31:0] imm_sx;
    logic [31:0] imm_zx;
    logic [31:0] pc4;

    logic [31:0] ea;
    logic [2:0]  acc_len;
    logic [32:0] ea_end;
    logic        addr_ok;
    logic [31:0] pre_addr;
    logic [WIDX_BITS-1:0] pre_idx;
    logic [WIDX_BITS-1:0] ea_idx;

    logic                 mem_re;
    logic                 mem_we;
    logic [WIDX_BITS-1:0] mem_raddr;
    logic [WIDX_BITS-1:0] mem_waddr;
    logic [31:0]          mem_wdata;
    logic [31:0]          mem_rdata;

    logic [4:0]  byte_sh;
    logic [31:0] ld_shift;
    logic [31:0] ld_val;
    logic [31:0] st_mask;
    logic [31:0] st_val;
    logic [31:0] st_merge;
    logic        msign;
    logic [32:0] mul_a;
    logic [32:0] mul_b;
    logic signed [65:0] prod_full;

    logic          finish;
    logic          rf_we;
    mie_pkg::res_t res;

    mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk(clk), .we(rf_we), .waddr(res.reg_index), .wdata(res.reg_value),
        .re(rf_re), .raddr(q_item.iw[25:21]), .rdata(rf_rdata_a)
    );

    mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk(clk), .we(rf_we), .waddr(res.reg_index), .wdata(res.reg_value),
        .re(rf_re), .raddr(q_item.iw[20:16]), .rdata(rf_rdata_b)
    );

    mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
    );

    // operand decode; register-file entries never written read as zero
    always_comb
    begin
        a      = vld_a_reg ? rf_rdata_a : 32'd0;
        b      = vld_b_reg ? rf_rdata_b : 32'd0;
        iw     = item_reg.iw;
        opc    = iw[31:26];
        fn     = iw[5:0];
        rt     = iw[20:16];
        rdn    = iw[15:11];
        shamt  = iw[10:6];
        imm_sx = {{16{iw[15]}}, iw[15:0]};
        imm_zx = {16'd0, iw[15:0]};
        pc4    = pc_reg + 32'd4;

        ea = a + imm_sx;
        case (opc) inside
            mie_pkg::OPC_LB, mie_pkg::OPC_LBU, mie_pkg::OPC_SB: acc_len = 3'd1;
            mie_pkg::OPC_LH, mie_pkg::OPC_LHU, mie_pkg::OPC_SH: acc_len = 3'd2;
            default:                                            acc_len = 3'd4;
        endcase
        ea_end  = {1'b0, ea} + {30'd0, acc_len};
        addr_ok = (ea != 32'd0) && (ea_end[32:MEM_ADDR_BITS] == '0)
                  && !(acc_len[1] && ea[0]) && !(acc_len[2] && (ea[1:0] != 2'd0));
        pre_addr = {{(32 - mie_pkg::LOAD_ADDR_W){1'b0}}, item_reg.load_address};
        pre_idx  = pre_addr[MEM_ADDR_BITS-1:2];
        ea_idx   = ea[MEM_ADDR_BITS-1:2];

        byte_sh  = {ea[1:0], 3'b000};
        ld_shift = mem_rdata >> byte_sh;
        case (opc)
            mie_pkg::OPC_LB:  ld_val = {{24{ld_shift[7]}}, ld_shift[7:0]};
            mie_pkg::OPC_LBU: ld_val = {24'd0, ld_shift[7:0]};
            mie_pkg::OPC_LH:  ld_val = {{16{ld_shift[15]}}, ld_shift[15:0]};
            mie_pkg::OPC_LHU: ld_val = {16'd0, ld_shift[15:0]};
            default:          ld_val = ld_shift;
        endcase
        case (opc)
            mie_pkg::OPC_SB: st_mask = 32'h0000_00ff;
            mie_pkg::OPC_SH: st_mask = 32'h0000_ffff;
            default:         st_mask = 32'hffff_ffff;
        endcase
        st_val   = b & st_mask;
        st_merge = (mem_rdata & ~(st_mask << byte_sh)) | (st_val << byte_sh);

        msign     = (item_reg.cls == mie_pkg::CL_MULT);
        mul_a     = {msign & a[31], a};
        mul_b     = {msign & b[31], b};
        prod_full = $signed(mul_a) * $signed(mul_b);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mie_pkg::BS_IDLE:
            begin
                if (q_valid && !out_vld_reg)
                begin
                    state_next = mie_pkg::BS_EXEC;
                end
            end
            mie_pkg::BS_EXEC:
            begin
                case (item_reg.cls) inside
                    mie_pkg::CL_MULT, mie_pkg::CL_MULTU: state_next = mie_pkg::BS_MUL;
                    mie_pkg::CL_PRD:                     state_next = mie_pkg::BS_MEM;
                    mie_pkg::CL_LOAD, mie_pkg::CL_STORE:
                        state_next = addr_ok ? mie_pkg::BS_MEM : mie_pkg::BS_IDLE;
                    default:                             state_next = mie_pkg::BS_IDLE;
                endcase
            end
            mie_pkg::BS_MUL: state_next = mie_pkg::BS_IDLE;
            mie_pkg::BS_MEM: state_next = mie_pkg::BS_IDLE;
            default:         state_next = mie_pkg::BS_IDLE;
        endcase
    end

    // outputs and result
    always_comb
    begin
        q_pop     = 1'b0;
        rf_re     = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = (item_reg.cls == mie_pkg::CL_PRD) ? pre_idx : ea_idx;
        mem_waddr = (item_reg.cls == mie_pkg::CL_PWR) ? pre_idx : ea_idx;
        mem_wdata = (item_reg.cls == mie_pkg::CL_PWR) ? item_reg.load_data : st_merge;
        finish    = 1'b0;
        prod_next = prod_reg;
        res         = '0;
        res.status  = mie_pkg::ST_OK;
        res.next_pc = pc_reg;
        case (state_reg)
            mie_pkg::BS_IDLE:
            begin
                if (q_valid && !out_vld_reg)
                begin
                    q_pop = 1'b1;
                    rf_re = 1'b1;
                end
            end
            mie_pkg::BS_EXEC:
            begin
                finish = 1'b1;
                case (item_reg.cls)
                    mie_pkg::CL_MULT, mie_pkg::CL_MULTU:
                    begin
                        finish    = 1'b0;
                        prod_next = prod_full[63:0];
                    end
                    mie_pkg::CL_LOAD, mie_pkg::CL_STORE:
                    begin
                        if (addr_ok)
                        begin
                            finish = 1'b0;
                            mem_re = 1'b1;
                        end
                        else
                        begin
                            res.status = mie_pkg::ST_BADADDR;
                        end
                    end
                    mie_pkg::CL_PRD:
                    begin
                        finish = 1'b0;
                        mem_re = 1'b1;
                    end
                    mie_pkg::CL_PWR:
                    begin
                        mem_we = 1'b1;
                    end
                    mie_pkg::CL_ILLEGAL:
                    begin
                        res.status = mie_pkg::ST_ILLEGAL;
                    end
                    mie_pkg::CL_RTYPE:
                    begin
                        res.next_pc     = pc4;
                        res.reg_written = 1'b1;
                        res.reg_index   = rdn;
                        case (fn)
                            mie_pkg::FN_SLL:  res.reg_value = b << shamt;
                            mie_pkg::FN_SRL:  res.reg_value = b >> shamt;
                            mie_pkg::FN_SRA:  res.reg_value = 32'($signed(b) >>> shamt);
                            mie_pkg::FN_JALR:
                            begin
                                res.reg_value = pc4;
                                res.next_pc   = a;
                            end
                            mie_pkg::FN_MFHI: res.reg_value = hi_reg;
                            mie_pkg::FN_MFLO: res.reg_value = lo_reg;
                            mie_pkg::FN_ADDU: res.reg_value = a + b;
                            mie_pkg::FN_SUBU: res.reg_value = a - b;
                            mie_pkg::FN_AND:  res.reg_value = a & b;
                            mie_pkg::FN_OR:   res.reg_value = a | b;
                            mie_pkg::FN_XOR:  res.reg_value = a ^ b;
                            mie_pkg::FN_NOR:  res.reg_value = ~(a | b);
                            mie_pkg::FN_SLT:  res.reg_value = {31'd0, $signed(a) < $signed(b)};
                            mie_pkg::FN_SLTU: res.reg_value = {31'd0, a < b};
                            default:          res.reg_value = 32'd0;
                        endcase
                    end
                    mie_pkg::CL_JR:
                    begin
                        res.next_pc   = a;
                        res.reg_index = rdn;
                    end
                    mie_pkg::CL_SYSCALL:
                    begin
                        res.status    = mie_pkg::ST_SYSCALL;
                        res.next_pc   = pc4;
                        res.reg_index = rdn;
                    end
                    mie_pkg::CL_JUMP:
                    begin
                        res.next_pc = (pc4 & mie_pkg::PC_SEG_MASK) | {4'd0, iw[25:0], 2'b00};
                        if (opc == mie_pkg::OPC_JAL)
                        begin
                            res.reg_written = 1'b1;
                            res.reg_index   = 5'd31;
                            res.reg_value   = pc4;
                        end
                    end
                    mie_pkg::CL_BRANCH:
                    begin
                        res.next_pc = pc4;
                        if ((opc == mie_pkg::OPC_BEQ) == (a == b))
                        begin
                            res.next_pc = pc4 + {imm_sx[29:0], 2'b00};
                        end
                    end
                    mie_pkg::CL_IMM:
                    begin
                        res.next_pc     = pc4;
                        res.reg_written = 1'b1;
                        res.reg_index   = rt;
                        case (opc)
                            mie_pkg::OPC_ADDIU: res.reg_value = a + imm_sx;
                            mie_pkg::OPC_SLTI:
                                res.reg_value = {31'd0, $signed(a) < $signed(imm_sx)};
                            mie_pkg::OPC_SLTIU: res.reg_value = {31'd0, a < imm_sx};
                            mie_pkg::OPC_ANDI:  res.reg_value = a & imm_zx;
                            mie_pkg::OPC_ORI:   res.reg_value = a | imm_zx;
                            mie_pkg::OPC_XORI:  res.reg_value = a ^ imm_zx;
                            default:            res.reg_value = {iw[15:0], 16'd0};
                        endcase
                    end
                    default:
                    begin
                        res.next_pc = pc_reg;
                    end
                endcase
            end
            mie_pkg::BS_MUL:
            begin
                finish        = 1'b1;
                res.next_pc   = pc4;
                res.reg_index = rdn;
            end
            mie_pkg::BS_MEM:
            begin
                finish = 1'b1;
                case (item_reg.cls)
                    mie_pkg::CL_LOAD:
                    begin
                        res.next_pc     = pc4;
                        res.reg_written = 1'b1;
                        res.reg_index   = rt;
                        res.reg_value   = ld_val;
                    end
                    mie_pkg::CL_STORE:
                    begin
                        mem_we            = 1'b1;
                        res.next_pc       = pc4;
                        res.mem_written   = 1'b1;
                        res.store_address = ea;
                        res.store_value   = st_val;
                    end
                    default:
                    begin
                        res.read_data = mem_rdata;
                    end
                endcase
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
        rf_we = finish && res.reg_written;
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mie_pkg::BS_IDLE;
            rf_vld_reg  <= 32'd0;
            pc_reg      <= 32'd0;
            hi_reg      <= 32'd0;
            lo_reg      <= 32'd0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rf_we)
            begin
                rf_vld_reg[res.reg_index] <= 1'b1;
            end
            if (cfg.valid)
            begin
                pc_reg <= cfg.start_pc;
            end
            else if (finish)
            begin
                pc_reg <= res.next_pc;
            end
            if (state_reg == mie_pkg::BS_MUL)
            begin
                hi_reg <= prod_reg[63:32];
                lo_reg <= prod_reg[31:0];
            end
            if (finish)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (q_pop)
        begin
            item_reg  <= q_item;
            vld_a_reg <= rf_vld_reg[q_item.iw[25:21]];
            vld_b_reg <= rf_vld_reg[q_item.iw[20:16]];
        end
        if (finish)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.next_pc       = out_reg.next_pc;
    assign rsp.reg_written   = out_reg.reg_written;
    assign rsp.reg_index     = out_reg.reg_index;
    assign rsp.reg_value     = out_reg.reg_value;
    assign rsp.mem_written   = out_reg.mem_written;
    assign rsp.store_address = out_reg.store_address;
    assign rsp.store_value   = out_reg.store_value;
    assign rsp.read_data     = out_reg.read_data;

endmodule

// ===== rtl/mips_instruction_executor.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Carries
// req     | in  | operation, instruction_word, load_address, load_data
// rsp     | out | status, next_pc, reg_written/index/value, store fields, read_data
// cfg     | in  | start_pc (also loads the PC), always ready
//
// Per transaction the executor steps through dequeue with register-file read, execute and
// result register for ALU, branch, jump, syscall and preload write; loads, stores, preload
// reads and multiplies add a memory read or multiplier register stage before the result;
// a load or store whose address faults ends after execute.
// The next item is dequeued once the result register is taken.
// Reset clears PC, HI/LO, register-file valid bits and the queue; memory is not cleared.
// A 2-entry queue keeps req ready while the executor or rsp stalls, until both entries fill.
`include "mips_instruction_executor_assert.svh"
module mips_instruction_executor #(
    parameter int MEM_ADDR_BITS = 20
) (
    input  logic       clk,
    input  logic       rst_n,
    mie_req_if.sink    req,
    mie_rsp_if.source  rsp,
    mie_cfg_if.sink    cfg
);

    logic           q_valid;
    mie_pkg::item_t q_item;
    logic           q_pop;

    mie_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    mie_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
        .cfg(cfg), .rsp(rsp)
    );

    `MIE_ASSERT_NXT(a_push_queued, req.valid && req.ready, q_valid)
    `MIE_ASSERT_IMP(a_illegal_quiet,
        rsp.valid && rsp.status == mie_pkg::ST_ILLEGAL,
        !rsp.reg_written && !rsp.mem_written && rsp.reg_index == 5'd0)
    `MIE_ASSERT_IMP(a_one_write, rsp.valid, !(rsp.reg_written && rsp.mem_written))

endmodule

// ===== dv/mie_scoreboard.sv =====
`timescale 1ns / 1ps
module mie_scoreboard (
    input  logic clk,
    input  logic rst_n,
    mie_req_if   req,
    mie_rsp_if   rsp,
    mie_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    logic [31:0]   gpr [32];
    logic [31:0]   pc_q;
    logic [31:0]   hi_q;
    logic [31:0]   lo_q;
    logic [31:0]   mem_words [int unsigned];
    mie_pkg::res_t expected_q [$];

    function automatic logic [31:0] mem_rd(int unsigned idx);
        if (mem_words.exists(idx))
        begin
            return mem_words[idx];
        end
        return 32'h0;
    endfunction

    function automatic bit addr_ok(logic [31:0] a, int unsigned len);
        logic [32:0] sum;
        sum = {1'b0, a} + 33'(len);
        if (a == 32'h0)
        begin
            return 0;
        end
        if (sum >= 33'h100000)
        begin
            return 0;
        end
        if ((a & (len - 1)) != 0)
        begin
            return 0;
        end
        return 1;
    endfunction

    function automatic int unsigned access_len(logic [5:0] opc);
        case (opc)
            mie_pkg::OPC_LB, mie_pkg::OPC_LBU, mie_pkg::OPC_SB: return 1;
            mie_pkg::OPC_LH, mie_pkg::OPC_LHU, mie_pkg::OPC_SH: return 2;
            default: return 4;
        endcase
    endfunction

    function automatic mie_pkg::res_t exec_step(logic [1:0] op, logic [31:0] iw,
                                                logic [mie_pkg::LOAD_ADDR_W-1:0] la,
                                                logic [31:0] ld);
        mie_pkg::res_t r;
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rdn;
        logic [4:0]  sh;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm_s;
        logic [31:0] imm_z;
        logic [31:0] ea;
        logic [31:0] pc;
        logic [31:0] w;
        logic [31:0] mask;
        logic [63:0] p;
        int unsigned len;
        int unsigned bsh;
        r = '0;
        pc = pc_q;
        r.next_pc = pc_q;
        case (op)
            mie_pkg::OP_WRITE: mem_words[int'(la[19:2])] = ld;
            mie_pkg::OP_READ:  r.read_data = mem_rd(la[19:2]);
            mie_pkg::OP_EXEC:
            begin
                opc = iw[31:26];
                rs = iw[25:21];
                rt = iw[20:16];
                rdn = iw[15:11];
                sh = iw[10:6];
                fn = iw[5:0];
                imm_z = {16'h0, iw[15:0]};
                imm_s = {{16{iw[15]}}, iw[15:0]};
                a = gpr[rs];
                b = gpr[rt];
                ea = a + imm_s;
                r.next_pc = pc + 32'd4;
                if (opc == mie_pkg::OPC_SPECIAL)
                begin
                    r.reg_written = 1'b1;
                    r.reg_index = rdn;
                    case (fn)
                        mie_pkg::FN_SLL:  r.reg_value = b << sh;
                        mie_pkg::FN_SRL:  r.reg_value = b >> sh;
                        mie_pkg::FN_SRA:  r.reg_value = $signed(b) >>> sh;
                        mie_pkg::FN_JR:
                        begin
                            r.reg_written = 1'b0;
                            r.next_pc = a;
                        end
                        mie_pkg::FN_JALR:
                        begin
                            r.reg_value = pc + 32'd4;
                            r.next_pc = a;
                        end
                        mie_pkg::FN_SYSCALL:
                        begin
                            r.reg_written = 1'b0;
                            r.status = mie_pkg::ST_SYSCALL;
                        end
                        mie_pkg::FN_MFHI: r.reg_value = hi_q;
                        mie_pkg::FN_MFLO: r.reg_value = lo_q;
                        mie_pkg::FN_MULT, mie_pkg::FN_MULTU:
                        begin
                            if (fn == mie_pkg::FN_MULT)
                            begin
                                p = 64'(longint'($signed(a)) * longint'($signed(b)));
                            end
                            else
                            begin
                                p = {32'h0, a} * {32'h0, b};
                            end
                            hi_q = p[63:32];
                            lo_q = p[31:0];
                            r.reg_written = 1'b0;
                        end
                        mie_pkg::FN_ADDU: r.reg_value = a + b;
                        mie_pkg::FN_SUBU: r.reg_value = a - b;
                        mie_pkg::FN_AND:  r.reg_value = a & b;
                        mie_pkg::FN_OR:   r.reg_value = a | b;
                        mie_pkg::FN_XOR:  r.reg_value = a ^ b;
                        mie_pkg::FN_NOR:  r.reg_value = ~(a | b);
                        mie_pkg::FN_SLT:  r.reg_value = 32'($signed(a) < $signed(b));
                        mie_pkg::FN_SLTU: r.reg_value = 32'(a < b);
                        default:
                        begin
                            r.reg_written = 1'b0;
                            r.reg_index = '0;
                            r.status = mie_pkg::ST_ILLEGAL;
                            r.next_pc = pc;
                        end
                    endcase
                end
                else
                begin
                    r.reg_index = rt;
                    case (opc)
                        mie_pkg::OPC_J:
                            r.next_pc = ((pc + 32'd4) & mie_pkg::PC_SEG_MASK)
                                        | {4'h0, iw[25:0], 2'b00};
                        mie_pkg::OPC_JAL:
                        begin
                            r.reg_written = 1'b1;
                            r.reg_index = 5'd31;
                            r.reg_value = pc + 32'd4;
                            r.next_pc = ((pc + 32'd4) & mie_pkg::PC_SEG_MASK)
                                        | {4'h0, iw[25:0], 2'b00};
                        end
                        mie_pkg::OPC_BEQ:
                        begin
                            if (a == b)
                            begin
                                r.next_pc = pc + 32'd4 + (imm_s << 2);
                            end
                        end
                        mie_pkg::OPC_BNE:
                        begin
                            if (a != b)
                            begin
                                r.next_pc = pc + 32'd4 + (imm_s << 2);
                            end
                        end
                        mie_pkg::OPC_ADDIU, mie_pkg::OPC_SLTI, mie_pkg::OPC_SLTIU,
                        mie_pkg::OPC_ANDI, mie_pkg::OPC_ORI, mie_pkg::OPC_XORI,
                        mie_pkg::OPC_LUI:
                        begin
                            r.reg_written = 1'b1;
                            case (opc)
                                mie_pkg::OPC_ADDIU: r.reg_value = a + imm_s;
                                mie_pkg::OPC_SLTI:
                                    r.reg_value = 32'($signed(a) < $signed(imm_s));
                                mie_pkg::OPC_SLTIU: r.reg_value = 32'(a < imm_s);
                                mie_pkg::OPC_ANDI:  r.reg_value = a & imm_z;
                                mie_pkg::OPC_ORI:   r.reg_value = a | imm_z;
                                mie_pkg::OPC_XORI:  r.reg_value = a ^ imm_z;
                                default:            r.reg_value = imm_z << 16;
                            endcase
                        end
                        mie_pkg::OPC_LB, mie_pkg::OPC_LH, mie_pkg::OPC_LW,
                        mie_pkg::OPC_LBU, mie_pkg::OPC_LHU:
                        begin
                            len = access_len(opc);
                            if (!addr_ok(ea, len))
                            begin
                                r.status = mie_pkg::ST_BADADDR;
                                r.next_pc = pc;
                            end
                            else
                            begin
                                w = mem_rd(ea[19:2]) >> (8 * ea[1:0]);
                                case (opc)
                                    mie_pkg::OPC_LB:  r.reg_value = {{24{w[7]}}, w[7:0]};
                                    mie_pkg::OPC_LBU: r.reg_value = {24'h0, w[7:0]};
                                    mie_pkg::OPC_LH:  r.reg_value = {{16{w[15]}}, w[15:0]};
                                    mie_pkg::OPC_LHU: r.reg_value = {16'h0, w[15:0]};
                                    default:          r.reg_value = w;
                                endcase
                                r.reg_written = 1'b1;
                            end
                        end
                        mie_pkg::OPC_SB, mie_pkg::OPC_SH, mie_pkg::OPC_SW:
                        begin
                            len = access_len(opc);
                            if (!addr_ok(ea, len))
                            begin
                                r.status = mie_pkg::ST_BADADDR;
                                r.next_pc = pc;
                            end
                            else
                            begin
                                mask = (len == 1) ? 32'hff : (len == 2) ? 32'hffff : 32'hffffffff;
                                bsh = 8 * ea[1:0];
                                w = mem_rd(ea[19:2]);
                                r.mem_written = 1'b1;
                                r.store_address = ea;
                                r.store_value = b & mask;
                                mem_words[int'(ea[19:2])] =
                                    (w & ~(mask << bsh)) | (r.store_value << bsh);
                            end
                        end
                        default:
                        begin
                            r.status = mie_pkg::ST_ILLEGAL;
                            r.next_pc = pc;
                        end
                    endcase
                    if (!r.reg_written)
                    begin
                        r.reg_index = '0;
                    end
                end
                if (r.reg_written)
                begin
                    gpr[r.reg_index] = r.reg_value;
                end
                pc_q = r.next_pc;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int field_diff(string name, logic [31:0] e, logic [31:0] g);
        if (e !== g)
        begin
            $error("%s: expected %h, actual %h", name, e, g);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        mie_pkg::res_t exp_r;
        int            errs;
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
            begin
                gpr[i] = '0;
            end
            pc_q = '0;
            hi_q = '0;
            lo_q = '0;
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg.valid && cfg.ready)
            begin
                pc_q = cfg.start_pc;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("response transaction with nothing outstanding");
                    errs++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    errs += field_diff("status", 32'(exp_r.status), 32'(rsp.status));
                    errs += field_diff("next_pc", exp_r.next_pc, rsp.next_pc);
                    errs += field_diff("reg_written", 32'(exp_r.reg_written),
                                       32'(rsp.reg_written));
                    errs += field_diff("reg_index", 32'(exp_r.reg_index), 32'(rsp.reg_index));
                    errs += field_diff("reg_value", exp_r.reg_value, rsp.reg_value);
                    errs += field_diff("mem_written", 32'(exp_r.mem_written),
                                       32'(rsp.mem_written));
                    errs += field_diff("store_address", exp_r.store_address, rsp.store_address);
                    errs += field_diff("store_value", exp_r.store_value, rsp.store_value);
                    errs += field_diff("read_data", exp_r.read_data, rsp.read_data);
                end
            end
            if (req.valid && req.ready)
            begin
                expected_q.push_back(exec_step(req.operation, req.instruction_word,
                                               req.load_address, req.load_data));
            end
            fail_count <= fail_count + errs;
            pending <= expected_q.size();
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 160;
    localparam int LA_W        = mie_pkg::LOAD_ADDR_W;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   snd_idle;
    int   rcv_idle;
    int   items_sent;
    int   stall_cycles;

    bit          written [int unsigned];
    int unsigned written_list [$];

    mie_req_if req_ch ();
    mie_rsp_if rsp_ch ();
    mie_cfg_if cfg_ch ();

    mips_instruction_executor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    mie_scoreboard checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {mie_pkg::OPC_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic bit is_load(logic [5:0] opc);
        return opc inside {mie_pkg::OPC_LB, mie_pkg::OPC_LH, mie_pkg::OPC_LW,
                           mie_pkg::OPC_LBU, mie_pkg::OPC_LHU};
    endfunction

    function automatic bit known_opc(logic [5:0] opc);
        return opc inside {mie_pkg::OPC_SPECIAL, mie_pkg::OPC_J, mie_pkg::OPC_JAL,
                           mie_pkg::OPC_BEQ, mie_pkg::OPC_BNE, mie_pkg::OPC_ADDIU,
                           mie_pkg::OPC_SLTI, mie_pkg::OPC_SLTIU, mie_pkg::OPC_ANDI,
                           mie_pkg::OPC_ORI, mie_pkg::OPC_XORI, mie_pkg::OPC_LUI,
                           mie_pkg::OPC_LB, mie_pkg::OPC_LH, mie_pkg::OPC_LW,
                           mie_pkg::OPC_LBU, mie_pkg::OPC_LHU, mie_pkg::OPC_SB,
                           mie_pkg::OPC_SH, mie_pkg::OPC_SW};
    endfunction

    function automatic bit known_fn(logic [5:0] fn);
        return fn inside {mie_pkg::FN_SLL, mie_pkg::FN_SRL, mie_pkg::FN_SRA, mie_pkg::FN_JR,
                          mie_pkg::FN_JALR, mie_pkg::FN_SYSCALL, mie_pkg::FN_MFHI,
                          mie_pkg::FN_MFLO, mie_pkg::FN_MULT, mie_pkg::FN_MULTU,
                          mie_pkg::FN_ADDU, mie_pkg::FN_SUBU, mie_pkg::FN_AND, mie_pkg::FN_OR,
                          mie_pkg::FN_XOR, mie_pkg::FN_NOR, mie_pkg::FN_SLT,
                          mie_pkg::FN_SLTU};
    endfunction

    task automatic send_item(logic [1:0] op, logic [31:0] iw, logic [LA_W-1:0] la,
                             logic [31:0] ld);
        while ($urandom_range(99) < snd_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.instruction_word <= iw;
        req_ch.load_address <= la;
        req_ch.load_data <= ld;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic exec(logic [31:0] iw);
        send_item(mie_pkg::OP_EXEC, iw, LA_W'($urandom), $urandom);
    endtask

    task automatic mark_word(int unsigned idx);
        if (!written.exists(idx))
        begin
            written[idx] = 1;
            written_list.push_back(idx);
        end
    endtask

    task automatic preload(logic [LA_W-1:0] la, logic [31:0] ld);
        send_item(mie_pkg::OP_WRITE, $urandom, la, ld);
        mark_word(la[19:2]);
    endtask

    // LUI/ORI pair, so the base value is known to the stimulus
    task automatic set_reg(logic [4:0] r, logic [31:0] v);
        exec(enc_i(mie_pkg::OPC_LUI, 5'($urandom), r, v[31:16]));
        exec(enc_i(mie_pkg::OPC_ORI, r, r, v[15:0]));
    endtask

    // load or store with effective address ea through a freshly set base register
    task automatic mem_access(logic [5:0] opc, logic [31:0] ea);
        logic [4:0]  rb;
        logic [15:0] imm;
        rb = 5'($urandom);
        imm = 16'($urandom);
        set_reg(rb, ea - {{16{imm[15]}}, imm});
        exec(enc_i(opc, rb, 5'($urandom), imm));
        if (opc == mie_pkg::OPC_SW && ea != 0 && ea < 32'h000ffffc && ea[1:0] == 2'b00)
        begin
            mark_word(ea[19:2]);
        end
    endtask

    function automatic logic [31:0] aligned_ea(logic [5:0] opc, int unsigned idx);
        logic [31:0] off;
        case (opc)
            mie_pkg::OPC_LB, mie_pkg::OPC_LBU, mie_pkg::OPC_SB: off = $urandom_range(0, 3);
            mie_pkg::OPC_LH, mie_pkg::OPC_LHU, mie_pkg::OPC_SH: off = 2 * $urandom_range(0, 1);
            default: off = 0;
        endcase
        return {idx[29:0], 2'b00} + off;
    endfunction

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h1;
            2: return 32'hffffffff;
            3: return 32'h80000000;
            4: return 32'h7fffffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_exec();
        logic [5:0]  fn_pool [18];
        logic [5:0]  imm_pool [7];
        logic [5:0]  opc;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [31:0] iw;
        fn_pool = '{mie_pkg::FN_SLL, mie_pkg::FN_SRL, mie_pkg::FN_SRA, mie_pkg::FN_JR,
                    mie_pkg::FN_JALR, mie_pkg::FN_SYSCALL, mie_pkg::FN_MFHI, mie_pkg::FN_MFLO,
                    mie_pkg::FN_MULT, mie_pkg::FN_MULTU, mie_pkg::FN_ADDU, mie_pkg::FN_SUBU,
                    mie_pkg::FN_AND, mie_pkg::FN_OR, mie_pkg::FN_XOR, mie_pkg::FN_NOR,
                    mie_pkg::FN_SLT, mie_pkg::FN_SLTU};
        imm_pool = '{mie_pkg::OPC_ADDIU, mie_pkg::OPC_SLTI, mie_pkg::OPC_SLTIU,
                     mie_pkg::OPC_ANDI, mie_pkg::OPC_ORI, mie_pkg::OPC_XORI, mie_pkg::OPC_LUI};
        rs = 5'($urandom);
        case ($urandom_range(0, 10))
            0, 1, 2: exec(enc_r(fn_pool[$urandom_range(0, 17)], rs, 5'($urandom),
                                5'($urandom), 5'($urandom)));
            3, 4: exec(enc_i(imm_pool[$urandom_range(0, 6)], rs, 5'($urandom),
                             16'($urandom)));
            5: exec(enc_i($urandom_range(0, 1) ? mie_pkg::OPC_BEQ : mie_pkg::OPC_BNE, rs,
                          $urandom_range(0, 1) ? rs : 5'($urandom), 16'($urandom)));
            6:
            begin
                case ($urandom_range(0, 3))
                    0: exec({mie_pkg::OPC_J, 26'($urandom)});
                    1: exec({mie_pkg::OPC_JAL, 26'($urandom)});
                    2: exec(enc_r(mie_pkg::FN_JR, rs, 5'($urandom), 5'($urandom),
                                  5'($urandom)));
                    default: exec(enc_r(mie_pkg::FN_JALR, rs, 5'($urandom),
                                        $urandom_range(0, 1) ? rs : 5'($urandom),
                                        5'($urandom)));
                endcase
            end
            7:
            begin
                exec(enc_r($urandom_range(0, 1) ? mie_pkg::FN_MULT : mie_pkg::FN_MULTU, rs,
                           5'($urandom), 5'($urandom), 5'($urandom)));
                exec(enc_r($urandom_range(0, 1) ? mie_pkg::FN_MFHI : mie_pkg::FN_MFLO,
                           5'($urandom), 5'($urandom), 5'($urandom), 5'($urandom)));
            end
            8: set_reg(5'($urandom), edge_value());
            9:
            begin
                // illegal opcode, illegal funct, or raw noise that is not a load
                case ($urandom_range(0, 2))
                    0:
                    begin
                        opc = 6'($urandom);
                        while (known_opc(opc))
                        begin
                            opc = 6'($urandom);
                        end
                        exec({opc, 26'($urandom)});
                    end
                    1:
                    begin
                        fn = 6'($urandom);
                        while (known_fn(fn))
                        begin
                            fn = 6'($urandom);
                        end
                        exec({mie_pkg::OPC_SPECIAL, 20'($urandom), fn});
                    end
                    default:
                    begin
                        iw = $urandom;
                        if (is_load(iw[31:26]))
                        begin
                            iw[31:26] = mie_pkg::OPC_SW;
                        end
                        exec(iw);
                    end
                endcase
            end
            default: send_item(mie_pkg::OP_NOP, $urandom, LA_W'($urandom), $urandom);
        endcase
    endtask

    task automatic random_mem_step();
        logic [5:0]  ld_pool [5];
        logic [5:0]  st_pool [3];
        logic [5:0]  opc;
        logic [31:0] ea;
        int unsigned idx;
        ld_pool = '{mie_pkg::OPC_LB, mie_pkg::OPC_LH, mie_pkg::OPC_LW, mie_pkg::OPC_LBU,
                    mie_pkg::OPC_LHU};
        st_pool = '{mie_pkg::OPC_SB, mie_pkg::OPC_SH, mie_pkg::OPC_SW};
        case ($urandom_range(0, 9))
            0:
            begin
                if ($urandom_range(0, 1))
                begin
                    preload(LA_W'($urandom), $urandom);
                end
                else
                begin
                    preload({9'h0, 4'h8, 5'($urandom_range(0, 31)), 2'($urandom)}, $urandom);
                end
            end
            1:
            begin
                idx = written_list[$urandom_range(0, written_list.size() - 1)];
                send_item(mie_pkg::OP_READ, $urandom, {idx[17:0], 2'($urandom)}, $urandom);
            end
            2, 3, 4:
            begin
                opc = ld_pool[$urandom_range(0, 4)];
                idx = written_list[$urandom_range(0, written_list.size() - 1)];
                mem_access(opc, aligned_ea(opc, idx));
            end
            5, 6:
            begin
                opc = st_pool[$urandom_range(0, 2)];
                if ($urandom_range(0, 1))
                begin
                    idx = written_list[$urandom_range(0, written_list.size() - 1)];
                end
                else
                begin
                    idx = 32'h100 + $urandom_range(0, 31);
                end
                mem_access(opc, aligned_ea(opc, idx));
            end
            7:
            begin
                // faulting access: null, misaligned, past the end, far out of range
                opc = $urandom_range(0, 1) ? ld_pool[$urandom_range(0, 4)]
                                           : st_pool[$urandom_range(0, 2)];
                case ($urandom_range(0, 3))
                    0: ea = 32'h0;
                    1: ea = {12'h0, 18'($urandom), 2'b01} + 32'($urandom_range(0, 1) * 2);
                    2: ea = 32'h00100000 - 32'($urandom_range(1, 4));
                    default: ea = $urandom | 32'h00100000;
                endcase
                if (opc inside {mie_pkg::OPC_LB, mie_pkg::OPC_LBU, mie_pkg::OPC_SB} &&
                    ea[31:20] == 12'h0 && ea != 0 && ea < 32'h000fffff)
                begin
                    ea = 32'h0;
                end
                mem_access(opc, ea);
            end
            default: random_exec();
        endcase
    endtask

    task automatic write_pc(logic [31:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.start_pc <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain(int settle);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic directed_items();
        write_pc(32'hfffffff0);
        exec(enc_i(mie_pkg::OPC_ADDIU, 5'd0, 5'd1, 16'hffff));
        exec(enc_i(mie_pkg::OPC_LUI, 5'd0, 5'd2, 16'h8000));
        exec(enc_r(mie_pkg::FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0));
        exec(enc_r(mie_pkg::FN_MFHI, 5'd0, 5'd0, 5'd3, 5'd0));
        exec(enc_r(mie_pkg::FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0));
        exec(enc_r(mie_pkg::FN_MFLO, 5'd0, 5'd0, 5'd4, 5'd0));
        exec(enc_r(mie_pkg::FN_SRA, 5'd0, 5'd2, 5'd5, 5'd31));
        exec(enc_r(mie_pkg::FN_SLT, 5'd2, 5'd1, 5'd6, 5'd0));
        exec(enc_r(mie_pkg::FN_SLTU, 5'd2, 5'd1, 5'd0, 5'd0));
        exec(enc_r(mie_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
        exec(enc_r(6'h3f, 5'd1, 5'd2, 5'd3, 5'd0));
        exec({6'h3f, 26'h3ffffff});
        send_item(mie_pkg::OP_NOP, 32'hffffffff, '1, 32'hffffffff);
        preload(20'hffffc, 32'h80ff7f01);
        preload(20'h00000, 32'h12345678);
        send_item(mie_pkg::OP_READ, 32'h0, 20'hfffff, 32'h0);
        mem_access(mie_pkg::OPC_LW, 32'h0);
        mem_access(mie_pkg::OPC_LB, 32'h000fffff);
        mem_access(mie_pkg::OPC_LB, 32'h000ffffe);
        mem_access(mie_pkg::OPC_LW, 32'h00000101);
        set_reg(5'd7, 32'h00400000);
        exec(enc_r(mie_pkg::FN_JALR, 5'd7, 5'd0, 5'd7, 5'd0));
        exec({mie_pkg::OPC_JAL, 26'h3ffffff});
        exec({mie_pkg::OPC_J, 26'h0});
    endtask

    initial
    begin
        int          target;
        logic [31:0] phase_pc [3];
        clk = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = '0;
        req_ch.instruction_word = '0;
        req_ch.load_address = '0;
        req_ch.load_data = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.start_pc = '0;
        snd_idle = 0;
        rcv_idle = 0;
        items_sent = 0;
        stall_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();

        phase_pc = '{32'h0, 32'hffffffff, $urandom};
        for (int ph = 0; ph < 3; ph++)
        begin
            snd_idle = (ph == 0) ? 25 : (ph == 1) ? 45 : 0;
            rcv_idle = (ph == 0) ? 45 : (ph == 1) ? 25 : 0;
            drain(10);
            write_pc(phase_pc[ph]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                random_mem_step();
            end
        end

        drain(20);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
